// ===== design/rmv_pkg.sv =====
// Shared types and constants for the running mean and variance block.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmv_pkg;

	localparam int DEF_COUNT_WIDTH  = 32;
	localparam int DEF_SAMPLE_WIDTH = 24;

	localparam int SUM_BITS       = 56;
	localparam int OUT_COUNT_BITS = 32;
	localparam int OUT_MEAN_BITS  = 24;
	localparam int OUT_DATA_BITS  = OUT_COUNT_BITS + OUT_MEAN_BITS + 2 * SUM_BITS + 1;
	localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

	localparam int POP_LSB = OUT_COUNT_BITS + OUT_MEAN_BITS;
	localparam int UNB_LSB = POP_LSB + SUM_BITS;
	localparam int SAT_BIT = UNB_LSB + SUM_BITS;

	localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MDIV_GO,
		ST_MDIV_WAIT,
		ST_MUL,
		ST_ACCUM,
		ST_VDIV_GO,
		ST_VDIV_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_sample;
		logic start_mdiv;
		logic upd_mean;
		logic mul;
		logic accum;
		logic start_vdiv;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic mdiv_done;
		logic vdiv_done;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/rmv_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Uses no package; instantiated by the datapath.
`timescale 1ns / 1ps
`default_nettype none

module rmv_divider #(
	parameter int NW = 25,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic      [NW-1:0] quotient,
	output logic               done
);

	localparam int CNTW = $clog2(NW + 1);

	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   div_q;

	logic [DW:0]     trial;
	logic [DW:0]     diff;
	logic            ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ===== design/rmv_datapath.sv =====
// Datapath: count, mean and squared deviation sum, the multiplier, the
// dividers and the result register. Depends on rmv_pkg and rmv_divider.
`timescale 1ns / 1ps
`default_nettype none

module rmv_datapath #(
	parameter int COUNT_WIDTH  = rmv_pkg::DEF_COUNT_WIDTH,
	parameter int SAMPLE_WIDTH = rmv_pkg::DEF_SAMPLE_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [SAMPLE_WIDTH-1:0]            sample,
	input  wire rmv_pkg::cmd_t                      cmd,
	output rmv_pkg::sts_t                           sts,
	output logic [rmv_pkg::OUT_DATA_BITS-1:0]       result
);

	import rmv_pkg::*;

	localparam int MAGW  = SAMPLE_WIDTH + 1;
	localparam int PRODW = 2 * MAGW;
	localparam int ACCW  = ((PRODW > SUM_BITS) ? PRODW : SUM_BITS) + 1;

	logic [COUNT_WIDTH-1:0]         count_q;
	logic signed [SAMPLE_WIDTH-1:0] mean_q;
	logic [SUM_BITS-1:0]            sum_q;
	logic                           sat_q;

	logic [SAMPLE_WIDTH-1:0]        sample_q;
	logic [MAGW-1:0]                delta_q;
	logic [PRODW-1:0]               prod_q;
	logic [OUT_DATA_BITS-1:0]       out_q;

	logic [MAGW-1:0]                sample_ext;
	logic [MAGW-1:0]                mean_ext;
	logic [MAGW-1:0]                delta_now;
	logic [MAGW-1:0]                delta_mag;
	logic [MAGW-1:0]                d1_mag;
	logic                           opposite;
	logic [PRODW-1:0]               prod_d;
	logic [MAGW-1:0]                mean_next;
	logic [ACCW-1:0]                acc_total;
	logic [COUNT_WIDTH-1:0]         pop_divisor;
	logic [COUNT_WIDTH-1:0]         unb_divisor;

	logic [MAGW-1:0]                mdiv_q;
	logic                           mdiv_done;
	logic [SUM_BITS-1:0]            pop_q;
	logic                           pop_done;
	logic [SUM_BITS-1:0]            unb_q;
	logic                           unb_done;

	assign sample_ext = {sample_q[SAMPLE_WIDTH-1], sample_q};
	assign mean_ext   = {mean_q[SAMPLE_WIDTH-1], mean_q};
	assign delta_now  = sample_ext - mean_ext;
	assign delta_mag  = delta_now[MAGW-1] ? (MAGW'(0) - delta_now) : delta_now;
	assign d1_mag     = delta_q[MAGW-1] ? (MAGW'(0) - delta_q) : delta_q;

	// In the multiply step delta_now is the deviation from the new mean.
	assign opposite = (delta_q[MAGW-1] && !delta_now[MAGW-1] && (delta_now != '0)) ||
	                  (!delta_q[MAGW-1] && (delta_q != '0) && delta_now[MAGW-1]);
	assign prod_d   = opposite ? '0 : (PRODW'(d1_mag) * PRODW'(delta_mag));

	assign mean_next = delta_q[MAGW-1] ? (mean_ext - mdiv_q) : (mean_ext + mdiv_q);
	assign acc_total = ACCW'(sum_q) + ACCW'(prod_q);

	assign pop_divisor = (count_q > COUNT_WIDTH'(1)) ? count_q : COUNT_WIDTH'(1);
	assign unb_divisor = (count_q > COUNT_WIDTH'(2)) ? (count_q - COUNT_WIDTH'(1)) :
	                     COUNT_WIDTH'(1);

	rmv_divider #(.NW(MAGW), .DW(COUNT_WIDTH)) u_mdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_mdiv),
		.dividend (delta_mag),
		.divisor  (count_q),
		.quotient (mdiv_q),
		.done     (mdiv_done)
	);

	rmv_divider #(.NW(SUM_BITS), .DW(COUNT_WIDTH)) u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_vdiv),
		.dividend (sum_q),
		.divisor  (pop_divisor),
		.quotient (pop_q),
		.done     (pop_done)
	);

	rmv_divider #(.NW(SUM_BITS), .DW(COUNT_WIDTH)) u_udiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_vdiv),
		.dividend (sum_q),
		.divisor  (unb_divisor),
		.quotient (unb_q),
		.done     (unb_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			sum_q   <= '0;
			sat_q   <= 1'b0;
		end else begin
			if (cmd.load_sample && (count_q != '1)) begin
				count_q <= count_q + COUNT_WIDTH'(1);
			end
			if (cmd.upd_mean) begin
				mean_q <= mean_next[SAMPLE_WIDTH-1:0];
			end
			if (cmd.accum) begin
				if (acc_total > ACCW'(SUM_MAX)) begin
					sum_q <= SUM_MAX;
					sat_q <= 1'b1;
				end else begin
					sum_q <= acc_total[SUM_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= sample;
		end
		if (cmd.start_mdiv) begin
			delta_q <= delta_now;
		end
		if (cmd.mul) begin
			prod_q <= prod_d;
		end
		if (cmd.load_out) begin
			out_q <= {sat_q, unb_q, pop_q, OUT_MEAN_BITS'(mean_q), OUT_COUNT_BITS'(count_q)};
		end
	end

	assign sts.mdiv_done = mdiv_done;
	assign sts.vdiv_done = pop_done && unb_done;
	assign result        = out_q;

endmodule

`default_nettype wire

// ===== design/rmv_controller.sv =====
// Controller state machine that sequences the datapath and owns both
// handshakes. Depends on rmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmv_controller (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	input  wire rmv_pkg::sts_t sts,
	output rmv_pkg::cmd_t      cmd
);

	import rmv_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_MDIV_GO;
				end
			end
			ST_MDIV_GO:   state_d = ST_MDIV_WAIT;
			ST_MDIV_WAIT: begin
				if (sts.mdiv_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:       state_d = ST_ACCUM;
			ST_ACCUM:     state_d = ST_VDIV_GO;
			ST_VDIV_GO:   state_d = ST_VDIV_WAIT;
			ST_VDIV_WAIT: begin
				if (sts.vdiv_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready        = 1'b1;
				cmd.load_sample = s_tvalid;
			end
			ST_MDIV_GO:   cmd.start_mdiv = 1'b1;
			ST_MDIV_WAIT: cmd.upd_mean   = sts.mdiv_done;
			ST_MUL:       cmd.mul        = 1'b1;
			ST_ACCUM:     cmd.accum      = 1'b1;
			ST_VDIV_GO:   cmd.start_vdiv = 1'b1;
			ST_VDIV_WAIT: cmd            = '0;
			ST_OUT:       cmd.load_out   = !m_tvalid_q || m_tready;
			default:      cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

// ===== design/running_mean_variance.sv =====
// Running mean and variance: one result request for each sample request.
// Each sample passes through the bit-serial mean division and the two
// variance divisions before its result is valid. A new sample is taken
// only once the previous one has been processed and its result loaded;
// a finished result waits in the output register meanwhile.
// Asynchronous active-low reset clears the count, mean, sum and flag.
`timescale 1ns / 1ps
`default_nettype none

module running_mean_variance #(
	parameter int COUNT_WIDTH  = rmv_pkg::DEF_COUNT_WIDTH,
	parameter int SAMPLE_WIDTH = rmv_pkg::DEF_SAMPLE_WIDTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// Fields from bit 0: sample.
	input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// Fields from bit 0: sample_count, running_mean, population_variance,
	// unbiased_variance, sum_saturated.
	output logic [rmv_pkg::OUT_TDATA_BITS-1:0]        m_tdata
);

	import rmv_pkg::*;

	cmd_t                     cmd;
	sts_t                     sts;
	logic [OUT_DATA_BITS-1:0] result;

	rmv_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmv_datapath #(
		.COUNT_WIDTH  (COUNT_WIDTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (s_tdata[SAMPLE_WIDTH-1:0]),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	assign m_tdata = OUT_TDATA_BITS'(result);

endmodule

`default_nettype wire

// ===== design/rmv_checker.sv =====
// Port-level assertions for running_mean_variance, bound to the top level.
// Depends on rmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmv_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [rmv_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

	import rmv_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sample taken while one is still being processed");

	a_var_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[UNB_LSB +: SUM_BITS] >= m_tdata[POP_LSB +: SUM_BITS]))
		else $error("sample variance below population variance");

endmodule

bind running_mean_variance rmv_checker u_rmv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
